FILE: rtl/core/ffsa_pkg.sv
// ---------------------------------------------------------------------------
// ffsa_pkg
// Shared widths, codes and types of the first free slot allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

	// Item field widths
	localparam int ITEM_W   = 10;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;

	// Request codes
	localparam logic FUNC_ASSIGN  = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;

	// Control state of the request sequencer
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// Commands broadcast to every slot cell
	typedef struct packed {
		logic              alloc;    // granted cell takes the slot
		logic              dealloc;  // selected cell frees its slot
		logic [ITEM_W-1:0] item;     // item being served
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ffsa_ram.sv
// ---------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ffsa_cell.sv
// ---------------------------------------------------------------------------
// ffsa_cell
// One worker slot: busy flag and owner item, plus one link of the
// lowest-free-slot search chain.
// ---------------------------------------------------------------------------
`default_nettype none

module ffsa_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ffsa_pkg::cell_ctl_t ctl,
	input  wire logic                sel,         // this slot is the one being freed
	input  wire logic                search_in,   // every lower slot is busy
	output logic                     search_out,  // this and every lower slot busy
	output logic                     grant        // this is the lowest free slot
);

	import ffsa_pkg::*;

	logic              busy_q;
	logic [ITEM_W-1:0] owner_q;

	// Search link: pass on only past a busy slot
	assign grant      = search_in & ~busy_q;
	assign search_out = search_in & busy_q;

	// Busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.alloc && grant) begin
			busy_q <= 1'b1;
		end else if (ctl.dealloc && sel) begin
			busy_q <= 1'b0;
		end
	end

	// Owner of the slot
	always_ff @(posedge clk) begin
		if (ctl.alloc && grant) begin
			owner_q <= ctl.item;
		end
	end

	// A freed slot must be busy and serve the item that releases it
	a_release_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dealloc && sel |-> busy_q && owner_q == ctl.item)
		else $error("slot freed by an item that does not own it");

endmodule

`default_nettype wire

FILE: rtl/core/first_free_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// first_free_slot_allocator_unit
// Hands out worker slots to item IDs: assign takes the lowest free slot,
// release frees the slot an item holds.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries func (0 assign, 1 release) and
//   item_id. Output channel out_valid/out_stall carries slot and status
//   (0 ok, 1 no free slot, 2 item held no slot). Every item gives one result.
//   The item is registered when taken, and its result is loaded into the
//   output register in the lookup state.
//   A new item is taken only after the last one's lookup; the item map sits
//   in a single RAM, read in the accept cycle and written in the lookup state.
//   Slots are a chain of NUM_SLOTS cells; the lowest free slot is found by
//   the search link rippling through the chain in the lookup cycle.
//   Reset: all slots free. After arst_n is released the item map is cleared
//   one entry per cycle, min(ITEM_COUNT, 1024) entries (1024 by default), with
//   in_stall held high throughout.
//   A stalled result stays in the output register; the next item is still
//   taken, and its lookup waits until the output register can be loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module first_free_slot_allocator_unit #(
	parameter int NUM_SLOTS  = 16,
	parameter int ITEM_COUNT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [ffsa_pkg::ITEM_W-1:0]    item_id,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [ffsa_pkg::SLOT_W-1:0]    slot,
	output logic      [ffsa_pkg::STATUS_W-1:0]  status
);

	import ffsa_pkg::*;

	localparam int ID_SPACE  = 2 ** ITEM_W;
	localparam int MAP_DEPTH = (ITEM_COUNT < ID_SPACE) ? ITEM_COUNT : ID_SPACE;
	localparam int AW        = $clog2(MAP_DEPTH);
	localparam int SW        = $clog2(NUM_SLOTS);
	localparam int MW        = SW + 1;

	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic              func_q;
	logic [ITEM_W-1:0] item_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [STATUS_W-1:0] status_q;

	logic              accept;
	logic              done;
	logic              item_ok;
	logic              any_free;
	logic [SW-1:0]     grant_idx;
	logic              do_alloc;
	logic              do_rel;

	logic              map_we;
	logic [AW-1:0]     map_waddr;
	logic [MW-1:0]     map_wdata;
	logic [MW-1:0]     map_rdata;
	logic              map_holds;
	logic [SW-1:0]     map_idx;

	cell_ctl_t              ctl;
	logic [NUM_SLOTS:0]     search;
	logic [NUM_SLOTS-1:0]   grant;
	logic [NUM_SLOTS-1:0]   sel;

	// Sequencer: clear sweep, wait for item, lookup and update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		done     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(MAP_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!out_valid_q || !out_stall) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid & ~in_stall;

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			item_q <= item_id;
		end
	end

	// Item map: holds flag and slot index per item
	ffsa_ram #(
		.WIDTH (MW),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (accept),
		.raddr (item_id[AW-1:0]),
		.rdata (map_rdata)
	);

	assign map_holds = map_rdata[MW-1];
	assign map_idx   = map_rdata[SW-1:0];

	// Decisions of the lookup cycle
	assign item_ok  = (32'(item_q) < ITEM_COUNT);
	assign any_free = ~search[NUM_SLOTS];
	assign do_alloc = done & (func_q == FUNC_ASSIGN) & item_ok & any_free;
	assign do_rel   = done & (func_q == FUNC_RELEASE) & item_ok & map_holds;

	// Map write: clearing sweep, or update on a successful request
	always_comb begin
		if (state_q == ST_CLEAR) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
			map_wdata = '0;
		end else begin
			map_we    = do_alloc | do_rel;
			map_waddr = item_q[AW-1:0];
			map_wdata = do_alloc ? {1'b1, grant_idx} : {1'b0, map_idx};
		end
	end

	// Slot chain
	assign ctl.alloc   = do_alloc;
	assign ctl.dealloc = do_rel;
	assign ctl.item    = item_q;
	assign search[0]   = 1'b1;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		assign sel[i] = (map_idx == SW'(i));

		ffsa_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (sel[i]),
			.search_in  (search[i]),
			.search_out (search[i+1]),
			.grant      (grant[i])
		);
	end

	// Encode the granted cell
	always_comb begin
		grant_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (grant[i]) begin
				grant_idx = grant_idx | SW'(i);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (do_alloc) begin
				slot_q   <= SLOT_W'(grant_idx);
				status_q <= STATUS_OK;
			end else if (do_rel) begin
				slot_q   <= SLOT_W'(map_idx);
				status_q <= STATUS_OK;
			end else if (func_q == FUNC_ASSIGN) begin
				slot_q   <= '0;
				status_q <= STATUS_NO_FREE;
			end else begin
				slot_q   <= '0;
				status_q <= STATUS_NOT_HELD;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign status    = status_q;

	// At most one cell wins the search
	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant))
		else $error("more than one slot granted");

	// A finished lookup always leaves a result behind
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("lookup finished without a result");

	// No result appears while the item map is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q)
		else $error("result during map clearing");

endmodule

`default_nettype wire
